// File: rtl/sbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by every module under rtl except sbs_ram; depends on nothing.
`default_nettype none

package sbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 10;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	// search bounds: room for one below zero and one above the last index
	localparam int BND_W       = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;

	typedef logic signed [BND_W-1:0] bnd_t;

	localparam bnd_t MAX_HI = BND_W'(TABLE_DEPTH - 1);

	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [IDX_W-1:0]          write_index;
		logic signed [DATA_W-1:0]  write_value;
		logic signed [DATA_W-1:0]  search_key;
		logic [IDX_W-1:0]          search_low;
		logic [IDX_W-1:0]          search_high;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_start;
		logic ram_we;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic start_empty;
		logic probe_done;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/sbs_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module sbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// File: rtl/sbs_ctrl.sv
// Controller for the binary search block: state machine and output valid.
// Depends on sbs_pkg for the state, command and status types.
`default_nettype none

module sbs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire sbs_pkg::op_t    req_op,
	output      logic            req_stall,
	output      logic            rsp_valid,
	input  wire logic            rsp_stall,
	input  wire sbs_pkg::stat_t  stat,
	output      sbs_pkg::cmd_t   cmd,
	output      sbs_pkg::state_t state
);

	sbs_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (req_valid && req_op == sbs_pkg::OP_SEARCH) begin
					state_d = stat.start_empty ? sbs_pkg::ST_FINISH : sbs_pkg::ST_PROBE;
				end
			end
			sbs_pkg::ST_PROBE: begin
				if (stat.probe_done) begin
					state_d = sbs_pkg::ST_FINISH;
				end
			end
			sbs_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = sbs_pkg::ST_IDLE;
				end
			end
			default: state_d = sbs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.load_start = (state_q == sbs_pkg::ST_IDLE) && req_valid
			&& (req_op == sbs_pkg::OP_SEARCH);
		cmd.ram_we     = (state_q == sbs_pkg::ST_IDLE) && req_valid
			&& (req_op == sbs_pkg::OP_WRITE);
		cmd.step       = (state_q == sbs_pkg::ST_PROBE);
		cmd.load_out   = (state_q == sbs_pkg::ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbs_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != sbs_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign state     = state_q;

endmodule

`default_nettype wire

// File: rtl/sbs_dp.sv
// Datapath for the binary search block: table RAM, bounds, probe compare, result.
// Depends on sbs_pkg and sbs_ram.
`default_nettype none

module sbs_dp (
	input  wire logic           clk,
	input  wire sbs_pkg::req_t  req,
	input  wire sbs_pkg::cmd_t  cmd,
	output      sbs_pkg::stat_t stat,
	output      sbs_pkg::rsp_t  rsp
);

	sbs_pkg::bnd_t lo_q, hi_q;
	logic [sbs_pkg::ADDR_W-1:0]        mid_q;
	logic signed [sbs_pkg::DATA_W-1:0] key_q;
	logic                              res_found_q;
	logic [sbs_pkg::IDX_W-1:0]         res_pos_q;
	sbs_pkg::rsp_t                     rsp_q;

	sbs_pkg::bnd_t start_lo, start_hi, hi_raw, start_sum;
	sbs_pkg::bnd_t mid_ext, next_lo, next_hi, next_sum;
	logic [sbs_pkg::ADDR_W-1:0]        start_mid, next_mid, ram_addr;
	logic [sbs_pkg::DATA_W-1:0]        ram_rdata;
	logic                              ram_we, hit, less, next_empty;

	// start of a search: saturate the top bound to the table
	assign start_lo  = sbs_pkg::bnd_t'(req.search_low);
	assign hi_raw    = sbs_pkg::bnd_t'(req.search_high);
	assign start_hi  = (hi_raw > sbs_pkg::MAX_HI) ? sbs_pkg::MAX_HI : hi_raw;
	assign start_sum = start_lo + start_hi;
	assign start_mid = sbs_pkg::ADDR_W'(start_sum >>> 1);

	// probe: compare the entry read last cycle and pick the next midpoint
	assign mid_ext    = sbs_pkg::bnd_t'(mid_q);
	assign hit        = (ram_rdata == key_q);
	assign less       = ($signed(ram_rdata) < key_q);
	assign next_lo    = less ? (mid_ext + sbs_pkg::bnd_t'(1)) : lo_q;
	assign next_hi    = less ? hi_q : (mid_ext - sbs_pkg::bnd_t'(1));
	assign next_empty = (next_lo > next_hi);
	assign next_sum   = next_lo + next_hi;
	assign next_mid   = sbs_pkg::ADDR_W'(next_sum >>> 1);

	assign stat.start_empty = (start_lo > start_hi);
	assign stat.probe_done  = hit || next_empty;

	// drop writes past the end of the table
	assign ram_we   = cmd.ram_we && (32'(req.write_index) < 32'(sbs_pkg::TABLE_DEPTH));
	always_comb begin
		if (cmd.ram_we) begin
			ram_addr = sbs_pkg::ADDR_W'(req.write_index);
		end else if (cmd.load_start) begin
			ram_addr = start_mid;
		end else begin
			ram_addr = next_mid;
		end
	end

	sbs_ram #(
		.WIDTH(sbs_pkg::DATA_W),
		.DEPTH(sbs_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(req.write_value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			lo_q        <= start_lo;
			hi_q        <= start_hi;
			mid_q       <= start_mid;
			key_q       <= req.search_key;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end else if (cmd.step) begin
			lo_q  <= next_lo;
			hi_q  <= next_hi;
			mid_q <= next_mid;
			if (hit) begin
				res_found_q <= 1'b1;
				res_pos_q   <= sbs_pkg::IDX_W'(mid_q);
			end
		end
		if (cmd.load_out) begin
			rsp_q.found    <= res_found_q;
			rsp_q.position <= res_pos_q;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: rtl/sorted_table_binary_search.sv
// Binary search over a sorted table of signed 32-bit entries.
// Request channel (req_valid, req_stall, req): a transaction is taken at a
// clock edge with req_valid high and req_stall low. A write transaction
// stores write_value at write_index and gives no response.
// A search transaction probes the midpoint of [search_low, search_high],
// one table RAM read per cycle, and narrows the range until a match or an
// empty range; search_high is clipped to the last table entry.
// Response channel (rsp_valid, rsp_stall, rsp): one transaction per search,
// found plus the match position (zero when not found).
// Flow control: a search holds req_stall from its acceptance until its
// result is loaded into the response register; each probe is one read of
// the single-port table RAM. An empty range skips the probe state. The
// response register is loaded as the search leaves its finish state; a
// stalled response holds while the next transaction is taken, and a search
// finishing behind it waits until the register frees.
// Reset clears control state only; table contents are undefined until
// written, and searching an unwritten entry gives an undefined result.
// Depends on sbs_pkg, sbs_ctrl, sbs_dp and sbs_ram.
`default_nettype none

module sorted_table_binary_search (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_stall,
	input  wire sbs_pkg::req_t req,
	output      logic          rsp_valid,
	input  wire logic          rsp_stall,
	output      sbs_pkg::rsp_t rsp
);

	sbs_pkg::cmd_t   cmd;
	sbs_pkg::stat_t  stat;
	sbs_pkg::state_t state;

	sbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.op),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	sbs_dp u_dp (
		.clk (clk),
		.req (req),
		.cmd (cmd),
		.stat(stat),
		.rsp (rsp)
	);

`ifndef SYNTHESIS
	// never overwrite a response that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> !cmd.load_out)
		else $error("response overwritten while stalled");

	// an accepted search keeps the request side stalled next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.op == sbs_pkg::OP_SEARCH |=> req_stall)
		else $error("search accepted without stalling the request side");

	// table writes come only from accepted write transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_we |-> req_valid && !req_stall && req.op == sbs_pkg::OP_WRITE)
		else $error("table write without a write transaction");

	// a response is loaded only after a search finished
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state) == sbs_pkg::ST_FINISH)
		else $error("response raised outside the finish state");
`endif

endmodule

`default_nettype wire

// File: dv/sorted_table_binary_search_test.sv
// Self-checking testbench for sorted_table_binary_search: fills the table, runs
// edge-case searches, then random sorted and unsorted traffic with random idling.
// Depends on sbs_pkg and the RTL under rtl.
module sorted_table_binary_search_test;

	localparam logic signed [sbs_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [sbs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	sbs_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	sbs_pkg::rsp_t rsp;

	logic signed [sbs_pkg::DATA_W-1:0] table_shadow [sbs_pkg::TABLE_DEPTH];
	sbs_pkg::rsp_t search_answers [$];
	int errors;
	int n_writes;
	int n_searches;
	int n_hits;
	bit no_idle;

	sorted_table_binary_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Walk the same probe sequence the block takes, midpoint rounded down.
	function automatic sbs_pkg::rsp_t probe_table_search(
			input logic signed [sbs_pkg::DATA_W-1:0] key,
			input logic [sbs_pkg::IDX_W-1:0] lo_in, input logic [sbs_pkg::IDX_W-1:0] hi_in);
		int lo;
		int hi;
		int mid;
		sbs_pkg::rsp_t r;
		lo = lo_in;
		hi = hi_in;
		r = '0;
		if (hi > sbs_pkg::TABLE_DEPTH - 1) hi = sbs_pkg::TABLE_DEPTH - 1;
		while (lo <= hi && !r.found) begin
			mid = lo + (hi - lo) / 2;
			if (table_shadow[mid] == key) begin
				r.found = 1'b1;
				r.position = sbs_pkg::IDX_W'(mid);
			end else if (table_shadow[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return r;
	endfunction

	function automatic sbs_pkg::req_t mk_write(input int idx,
			input logic signed [sbs_pkg::DATA_W-1:0] val);
		sbs_pkg::req_t r;
		r.op = sbs_pkg::OP_WRITE;
		r.write_index = sbs_pkg::IDX_W'(idx);
		r.write_value = val;
		r.search_key = $urandom;
		r.search_low = sbs_pkg::IDX_W'($urandom);
		r.search_high = sbs_pkg::IDX_W'($urandom);
		return r;
	endfunction

	function automatic sbs_pkg::req_t mk_search(input logic signed [sbs_pkg::DATA_W-1:0] key,
			input int lo, input int hi);
		sbs_pkg::req_t r;
		r.op = sbs_pkg::OP_SEARCH;
		r.write_index = sbs_pkg::IDX_W'($urandom);
		r.write_value = $urandom;
		r.search_key = key;
		r.search_low = sbs_pkg::IDX_W'(lo);
		r.search_high = sbs_pkg::IDX_W'(hi);
		return r;
	endfunction

	task automatic record_transaction(input sbs_pkg::req_t r);
		sbs_pkg::rsp_t ans;
		if (r.op == sbs_pkg::OP_WRITE) begin
			if (r.write_index < sbs_pkg::TABLE_DEPTH) table_shadow[r.write_index] = r.write_value;
			n_writes++;
		end else begin
			ans = probe_table_search(r.search_key, r.search_low, r.search_high);
			search_answers.push_back(ans);
			n_searches++;
			if (ans.found) n_hits++;
		end
	endtask

	task automatic send_req(input sbs_pkg::req_t r);
		while (!no_idle && $urandom_range(0, 99) < 9) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		record_transaction(r);
	endtask

	task automatic pick_range(output int lo, output int hi);
		int a;
		int b;
		int c;
		a = $urandom_range(0, sbs_pkg::TABLE_DEPTH - 1);
		b = $urandom_range(0, sbs_pkg::TABLE_DEPTH - 1);
		c = $urandom_range(0, 99);
		if (c < 60) begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
		end else if (c < 75) begin
			lo = 0;
			hi = sbs_pkg::TABLE_DEPTH - 1;
		end else if (c < 90) begin
			lo = a;
			hi = a + $urandom_range(0, 7);
			if (hi > sbs_pkg::TABLE_DEPTH - 1) hi = sbs_pkg::TABLE_DEPTH - 1;
		end else begin
			// may come out empty
			lo = a;
			hi = b;
		end
	endtask

	// Strictly ascending fill from the most negative to the most positive value.
	task automatic test_table_load();
		logic [21:0] low_bits;
		for (int i = 0; i < sbs_pkg::TABLE_DEPTH; i++) begin
			low_bits = $urandom;
			if (i == 0) low_bits = '0;
			if (i == sbs_pkg::TABLE_DEPTH - 1) low_bits = '1;
			send_req(mk_write(i, {i[9:0], low_bits} ^ 32'h8000_0000));
		end
	endtask

	task automatic test_edge_searches();
		send_req(mk_search(VAL_MIN, 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(VAL_MAX, 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(table_shadow[511], 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(table_shadow[0] + 1, 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(VAL_MAX - 1, 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(0, 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(table_shadow[7], sbs_pkg::TABLE_DEPTH - 1, 0));
		send_req(mk_search(table_shadow[4], 5, 4));
		send_req(mk_search(table_shadow[300], 300, 300));
		send_req(mk_search(table_shadow[300] + 1, 300, 300));
		send_req(mk_search(table_shadow[0], 0, 0));
		send_req(mk_search(table_shadow[1023], 1023, 1023));
		// key present but outside the range
		send_req(mk_search(table_shadow[10], 20, 30));
		send_req(mk_search(table_shadow[40], 20, 30));
		send_req(mk_write(600, table_shadow[601]));
		send_req(mk_search(table_shadow[601], 0, sbs_pkg::TABLE_DEPTH - 1));
		send_req(mk_search(table_shadow[601], 600, 601));
		send_req(mk_write(0, VAL_MIN));
		send_req(mk_write(sbs_pkg::TABLE_DEPTH - 1, VAL_MAX));
		send_req(mk_search(VAL_MIN, 0, 1));
		send_req(mk_search(VAL_MAX, 1022, 1023));
	endtask

	// Writes keep the table ascending (duplicates allowed); searches often hit.
	task automatic test_sorted_traffic(input int count);
		int idx;
		int lo;
		int hi;
		int c;
		longint span;
		longint pick;
		logic signed [sbs_pkg::DATA_W-1:0] lo_v;
		logic signed [sbs_pkg::DATA_W-1:0] hi_v;
		logic signed [sbs_pkg::DATA_W-1:0] key;
		for (int k = 0; k < count; k++) begin
			no_idle = (k < 300);
			if ($urandom_range(0, 99) < 30) begin
				idx = $urandom_range(0, sbs_pkg::TABLE_DEPTH - 1);
				lo_v = (idx == 0) ? VAL_MIN : table_shadow[idx - 1];
				hi_v = (idx == sbs_pkg::TABLE_DEPTH - 1) ? VAL_MAX : table_shadow[idx + 1];
				span = longint'(hi_v) - longint'(lo_v);
				c = $urandom_range(0, 9);
				if (c == 0) pick = lo_v;
				else if (c == 1) pick = hi_v;
				else pick = longint'(lo_v) + (longint'($urandom) % (span + 1));
				send_req(mk_write(idx, pick[31:0]));
			end else begin
				pick_range(lo, hi);
				c = $urandom_range(0, 99);
				idx = (lo <= hi) ? $urandom_range(hi, lo)
					: $urandom_range(0, sbs_pkg::TABLE_DEPTH - 1);
				if (c < 45) key = table_shadow[idx];
				else if (c < 75) key = table_shadow[idx] + ($urandom_range(0, 1) ? 1 : -1);
				else if (c < 90) key = $urandom;
				else key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
				send_req(mk_search(key, lo, hi));
			end
		end
		no_idle = 0;
	endtask

	// Scatter arbitrary values so the probe path runs through an unsorted table.
	task automatic test_unsorted_probes(input int count);
		int lo;
		int hi;
		logic signed [sbs_pkg::DATA_W-1:0] key;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 40) begin
				send_req(mk_write($urandom_range(0, sbs_pkg::TABLE_DEPTH - 1), $urandom));
			end else begin
				pick_range(lo, hi);
				if ($urandom_range(0, 1))
					key = table_shadow[$urandom_range(0, sbs_pkg::TABLE_DEPTH - 1)];
				else key = $urandom;
				send_req(mk_search(key, lo, hi));
			end
		end
	endtask

	always @(posedge clk) begin
		rsp_stall <= !no_idle && ($urandom_range(0, 99) < 9);
	end

	always @(posedge clk) begin
		sbs_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (search_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected response found=%0b position=%0d", $time,
					rsp.found, rsp.position);
			end else begin
				want = search_answers.pop_front();
				if (rsp.found !== want.found) begin
					errors++;
					$display("%0t: found mismatch expected %0b actual %0b", $time,
						want.found, rsp.found);
				end
				if (rsp.position !== want.position) begin
					errors++;
					$display("%0t: position mismatch expected %0d actual %0d", $time,
						want.position, rsp.position);
				end
			end
		end
	end

	initial begin
		int drain;
		errors = 0;
		n_writes = 0;
		n_searches = 0;
		n_hits = 0;
		no_idle = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_table_load();
		test_edge_searches();
		test_sorted_traffic(500);
		test_unsorted_probes(250);

		req_valid <= 1'b0;
		drain = 0;
		while (search_answers.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (30) @(posedge clk);
		if (search_answers.size() != 0) begin
			errors++;
			$display("%0t: %0d search responses never arrived", $time, search_answers.size());
		end

		$display("Ran %0d table writes and %0d searches (%0d hits, %0d misses),", n_writes,
			n_searches, n_hits, n_searches - n_hits);
		$display("over sorted, duplicate and unsorted tables with random idling on both sides.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/sbs_pkg.sv
rtl/sbs_ram.sv
rtl/sbs_ctrl.sv
rtl/sbs_dp.sv
rtl/sorted_table_binary_search.sv
dv/sorted_table_binary_search_test.sv
